// ===== rtl/cxalu_pkg.sv =====
// Shared constants, operation codes and the CORDIC arctangent table for the complex ALU.
// No dependencies; the files that use it refer to it by scoped names.
package cxalu_pkg;

	localparam int unsigned DATA_WIDTH_DEF    = 16;
	localparam int unsigned FRAC_BITS_DEF     = 12;
	localparam int unsigned CORDIC_STAGES_DEF = 16;

	localparam int unsigned FUNC_W     = 3;
	localparam int unsigned GUARD      = 2;
	localparam int unsigned ANG_BITS   = 30;
	// signed angle, |z| < 4 rad
	localparam int unsigned ANG_W      = ANG_BITS + 3;
	localparam int unsigned GAIN_W     = 30;
	localparam int unsigned GAIN_SPLIT = 15;

	localparam logic [ANG_BITS:0] HALF_PI  = 31'd1686629713;
	localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;

	typedef logic [FUNC_W-1:0] func_t;

	localparam func_t FN_ADD   = 3'd0;
	localparam func_t FN_SUB   = 3'd1;
	localparam func_t FN_MUL   = 3'd2;
	localparam func_t FN_SCALE = 3'd3;
	localparam func_t FN_EQ    = 3'd4;
	localparam func_t FN_POLAR = 3'd5;

	// atan(2^-i), 30 fraction bits, rounded to nearest
	function automatic logic [ANG_BITS:0] atan_q30(input int unsigned i);
		logic [ANG_BITS:0] r;
		case (i)
			0: r = 31'd843314857;
			1: r = 31'd497837829;
			2: r = 31'd263043837;
			3: r = 31'd133525159;
			4: r = 31'd67021687;
			5: r = 31'd33543516;
			6: r = 31'd16775851;
			7: r = 31'd8388437;
			8: r = 31'd4194283;
			9: r = 31'd2097149;
			default: r = (i <= ANG_BITS) ? (31'd1 << (ANG_BITS - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cxalu_ifs.sv =====
// Valid/ready channel interfaces for the complex ALU: command words in, result words out.
// Depends on cxalu_pkg.
interface cxalu_in_if #(
	parameter int unsigned DATA_WIDTH = cxalu_pkg::DATA_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	cxalu_pkg::func_t              func;
	logic signed [DATA_WIDTH-1:0]  a_re;
	logic signed [DATA_WIDTH-1:0]  a_im;
	logic signed [DATA_WIDTH-1:0]  b_re;
	logic signed [DATA_WIDTH-1:0]  b_im;
	logic signed [DATA_WIDTH-1:0]  scale;

	modport source(output valid, func, a_re, a_im, b_re, b_im, scale, input ready);
	modport sink(input valid, func, a_re, a_im, b_re, b_im, scale, output ready);
endinterface

interface cxalu_out_if #(
	parameter int unsigned DATA_WIDTH = cxalu_pkg::DATA_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [DATA_WIDTH-1:0]  res_re;
	logic signed [DATA_WIDTH-1:0]  res_im;
	logic                          is_equal;
	logic        [DATA_WIDTH-1:0]  magnitude;
	logic signed [DATA_WIDTH-1:0]  phase;
	logic                          overflow;

	modport source(output valid, res_re, res_im, is_equal, magnitude, phase, overflow,
		input ready);
	modport sink(input valid, res_re, res_im, is_equal, magnitude, phase, overflow,
		output ready);
endinterface

// ===== rtl/cxalu_cell.sv =====
// One CORDIC vectoring cell: a fixed-shift micro-rotation plus a pass-through word.
// Depends on cxalu_pkg for the arctangent table.
module cxalu_cell #(
	parameter int unsigned STAGE = 0,
	parameter int unsigned XW    = 21,
	parameter int unsigned SW    = 83
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 prev_valid,
	input  logic signed [XW-1:0]                 prev_x,
	input  logic signed [XW-1:0]                 prev_y,
	input  logic signed [cxalu_pkg::ANG_W-1:0]   prev_z,
	input  logic        [SW-1:0]                 prev_side,
	output logic                                 next_valid,
	output logic signed [XW-1:0]                 next_x,
	output logic signed [XW-1:0]                 next_y,
	output logic signed [cxalu_pkg::ANG_W-1:0]   next_z,
	output logic        [SW-1:0]                 next_side
);

	localparam int unsigned ZW = cxalu_pkg::ANG_W;
	localparam logic signed [ZW-1:0] ATAN = ZW'(cxalu_pkg::atan_q30(STAGE));

	logic signed [XW-1:0] dx, dy, x_d, y_d;
	logic signed [ZW-1:0] z_d;
	logic                 valid_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic        [SW-1:0] side_q;

	always_comb begin
		dx = prev_y >>> STAGE;
		dy = prev_x >>> STAGE;
		if (!prev_y[XW-1]) begin
			x_d = prev_x + dx;
			y_d = prev_y - dy;
			z_d = prev_z + ATAN;
		end else begin
			x_d = prev_x - dx;
			y_d = prev_y + dy;
			z_d = prev_z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_d;
			y_q    <= y_d;
			z_q    <= z_d;
			side_q <= prev_side;
		end
	end

	assign next_valid = valid_q;
	assign next_x     = x_q;
	assign next_y     = y_q;
	assign next_z     = z_q;
	assign next_side  = side_q;

endmodule

// ===== rtl/cxalu_tail.sv =====
// Two-stage finishing unit: products and sums, then rounding, saturation and polar scaling.
// Depends on cxalu_pkg for codes and CORDIC constants.
module cxalu_tail #(
	parameter int unsigned DW = 16,
	parameter int unsigned FW = 12,
	parameter int unsigned XW = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                valid,
	input  cxalu_pkg::func_t                    func,
	input  logic signed [DW-1:0]                a_re,
	input  logic signed [DW-1:0]                a_im,
	input  logic signed [DW-1:0]                b_re,
	input  logic signed [DW-1:0]                b_im,
	input  logic signed [DW-1:0]                scale,
	input  logic signed [XW-1:0]                x,
	input  logic signed [cxalu_pkg::ANG_W-1:0]  z,
	output logic                                res_valid,
	output logic signed [DW-1:0]                res_re,
	output logic signed [DW-1:0]                res_im,
	output logic                                is_equal,
	output logic        [DW-1:0]                magnitude,
	output logic signed [DW-1:0]                phase,
	output logic                                overflow
);

	localparam int unsigned PW    = 2 * DW;
	localparam int unsigned PF    = DW - 3;
	localparam int unsigned ZW    = cxalu_pkg::ANG_W;
	localparam int unsigned GS    = cxalu_pkg::GAIN_SPLIT;
	localparam int unsigned GHW   = cxalu_pkg::GAIN_W - GS;
	localparam int unsigned MW    = XW + GS + 1;
	localparam int unsigned FULLW = XW + cxalu_pkg::GAIN_W + 2;
	localparam int unsigned MSH   = cxalu_pkg::ANG_BITS + cxalu_pkg::GUARD;

	localparam logic signed [GS:0]   GLO = {1'b0, cxalu_pkg::INV_GAIN[GS-1:0]};
	localparam logic signed [GHW:0]  GHI = {1'b0, cxalu_pkg::INV_GAIN[cxalu_pkg::GAIN_W-1:GS]};
	localparam logic signed [ZW-1:0] ZRND = ZW'(64'd1 << (cxalu_pkg::ANG_BITS - 1 - PF));
	localparam logic signed [PW+1:0] HALF = (PW+2)'(64'd1 << (FW - 1));
	localparam logic signed [PW+1:0] LIM_HI = {{(PW+3-DW){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [PW+1:0] LIM_LO = {{(PW+3-DW){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [FULLW-1:0] MRND = FULLW'(64'd1 << (MSH - 1));
	localparam logic signed [FULLW-1:0] MAG_MAX = {{(FULLW-DW){1'b0}}, {DW{1'b1}}};

	function automatic logic [DW:0] sat_w(input logic signed [PW+1:0] v);
		logic [DW:0] r;
		if (v > LIM_HI) begin
			r = {1'b1, LIM_HI[DW-1:0]};
		end else if (v < LIM_LO) begin
			r = {1'b1, LIM_LO[DW-1:0]};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// stage 1
	logic signed [DW-1:0] op_b;
	logic signed [DW:0]   sum_re, sum_im;
	logic signed [ZW-1:0] z_r;

	logic                  valid_s1;
	cxalu_pkg::func_t      func_s1;
	logic signed [PW-1:0]  p1_s1, p2_s1, p3_s1, p4_s1;
	logic signed [DW:0]    sum_re_s1, sum_im_s1;
	logic                  eq_s1, zero_s1;
	logic signed [MW-1:0]  ml_s1, mh_s1;
	logic signed [DW-1:0]  phase_s1;

	always_comb begin
		op_b = (func == cxalu_pkg::FN_SCALE) ? scale : b_re;
		if (func == cxalu_pkg::FN_SUB) begin
			sum_re = (DW+1)'(a_re) - (DW+1)'(b_re);
			sum_im = (DW+1)'(a_im) - (DW+1)'(b_im);
		end else begin
			sum_re = (DW+1)'(a_re) + (DW+1)'(b_re);
			sum_im = (DW+1)'(a_im) + (DW+1)'(b_im);
		end
		z_r = (z + ZRND) >>> (cxalu_pkg::ANG_BITS - PF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1   <= func;
			p1_s1     <= PW'(a_re) * PW'(op_b);
			p2_s1     <= PW'(a_im) * PW'(b_im);
			p3_s1     <= PW'(a_re) * PW'(b_im);
			p4_s1     <= PW'(a_im) * PW'(op_b);
			sum_re_s1 <= sum_re;
			sum_im_s1 <= sum_im;
			eq_s1     <= (a_re == b_re) && (a_im == b_im);
			zero_s1   <= (a_re == '0) && (a_im == '0);
			ml_s1     <= MW'(x) * MW'(GLO);
			mh_s1     <= MW'(x) * MW'(GHI);
			phase_s1  <= z_r[DW-1:0];
		end
	end

	// stage 2
	logic signed [PW+1:0]    re_w, im_w, re_r, im_r;
	logic signed [FULLW-1:0] mag_w, mag_sh;
	logic        [DW:0]      sat_re, sat_im;
	logic signed [DW-1:0]    re_d, im_d, ph_d;
	logic        [DW-1:0]    mag_d;
	logic                    eq_d, ov_d;

	always_comb begin
		if (func_s1 == cxalu_pkg::FN_MUL) begin
			re_w = (PW+2)'(p1_s1) - (PW+2)'(p2_s1);
			im_w = (PW+2)'(p3_s1) + (PW+2)'(p4_s1);
		end else begin
			re_w = (PW+2)'(p1_s1);
			im_w = (PW+2)'(p4_s1);
		end
		re_r = (re_w + HALF) >>> FW;
		im_r = (im_w + HALF) >>> FW;

		mag_w  = (FULLW'(mh_s1) <<< GS) + FULLW'(ml_s1) + MRND;
		mag_sh = mag_w >>> MSH;

		sat_re = '0;
		sat_im = '0;
		re_d   = '0;
		im_d   = '0;
		eq_d   = 1'b0;
		mag_d  = '0;
		ph_d   = '0;
		ov_d   = 1'b0;
		case (func_s1) inside
			cxalu_pkg::FN_ADD, cxalu_pkg::FN_SUB: begin
				sat_re = sat_w({{(PW+1-DW){sum_re_s1[DW]}}, sum_re_s1});
				sat_im = sat_w({{(PW+1-DW){sum_im_s1[DW]}}, sum_im_s1});
				re_d   = sat_re[DW-1:0];
				im_d   = sat_im[DW-1:0];
				ov_d   = sat_re[DW] | sat_im[DW];
			end
			cxalu_pkg::FN_MUL, cxalu_pkg::FN_SCALE: begin
				sat_re = sat_w(re_r);
				sat_im = sat_w(im_r);
				re_d   = sat_re[DW-1:0];
				im_d   = sat_im[DW-1:0];
				ov_d   = sat_re[DW] | sat_im[DW];
			end
			cxalu_pkg::FN_EQ: begin
				eq_d = eq_s1;
			end
			cxalu_pkg::FN_POLAR: begin
				if (!zero_s1) begin
					if (mag_sh[FULLW-1]) begin
						mag_d = '0;
					end else if (mag_sh > MAG_MAX) begin
						mag_d = '1;
					end else begin
						mag_d = mag_sh[DW-1:0];
					end
					ph_d = phase_s1;
				end
			end
			default: begin
			end
		endcase
	end

	logic                 valid_s2;
	logic signed [DW-1:0] re_s2, im_s2, ph_s2;
	logic        [DW-1:0] mag_s2;
	logic                 eq_s2, ov_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s2  <= re_d;
			im_s2  <= im_d;
			eq_s2  <= eq_d;
			mag_s2 <= mag_d;
			ph_s2  <= ph_d;
			ov_s2  <= ov_d;
		end
	end

	assign res_valid = valid_s2;
	assign res_re    = re_s2;
	assign res_im    = im_s2;
	assign is_equal  = eq_s2;
	assign magnitude = mag_s2;
	assign phase     = ph_s2;
	assign overflow  = ov_s2;

endmodule

// ===== rtl/cxalu_skid.sv =====
// Two-entry output buffer: registered ready toward the pipeline, registered word toward the sink.
// No dependencies.
module cxalu_skid #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] data,
	input  logic         ready,
	output logic         room,
	output logic         valid,
	output logic [W-1:0] word
);

	logic         main_v_q, spare_v_q;
	logic [W-1:0] main_q, spare_q;
	logic         take, push_ok;

	assign take    = !main_v_q || ready;
	assign push_ok = push && !spare_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q  <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (take) begin
			if (spare_v_q) begin
				main_v_q  <= 1'b1;
				spare_v_q <= 1'b0;
			end else begin
				main_v_q <= push_ok;
			end
		end else if (push_ok) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			main_q <= spare_v_q ? spare_q : data;
		end else if (push_ok) begin
			spare_q <= data;
		end
	end

	assign room  = !spare_v_q;
	assign valid = main_v_q;
	assign word  = main_q;

endmodule

// ===== rtl/complex_alu_with_polar_top.sv =====
// Complex ALU top: input register with quadrant fold, CORDIC cell chain, finishing unit, output buffer.
// Depends on cxalu_pkg, cxalu_ifs, cxalu_cell, cxalu_tail and cxalu_skid.
//
//  port  dir  word contents
//  cmd   in   func, a_re, a_im, b_re, b_im, scale
//  rsp   out  res_re, res_im, is_equal, magnitude, phase, overflow
//
// One word per cycle while the output buffer has room.
// A word passes through the input register, the CORDIC chain (one cell per micro-rotation),
// two tail stages and the output buffer.
// All operations run through the same chain so results leave in order.
// Pipeline freezes only when the output buffer's spare slot is full; cmd.ready is registered.
// Reset clears valid flags only.
module complex_alu_with_polar_top #(
	parameter int unsigned DATA_WIDTH    = cxalu_pkg::DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS     = cxalu_pkg::FRAC_BITS_DEF,
	parameter int unsigned CORDIC_STAGES = cxalu_pkg::CORDIC_STAGES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	cxalu_in_if.sink     cmd,
	cxalu_out_if.source  rsp
);

	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned N  = CORDIC_STAGES;
	localparam int unsigned XW = DW + cxalu_pkg::GUARD + 3;
	localparam int unsigned ZW = cxalu_pkg::ANG_W;
	localparam int unsigned FN = cxalu_pkg::FUNC_W;
	localparam int unsigned SW = FN + 5 * DW;
	localparam int unsigned OW = 4 * DW + 2;

	localparam logic signed [ZW-1:0] HP      = ZW'(cxalu_pkg::HALF_PI);
	localparam logic signed [DW-1:0] RES_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] RES_MIN = {1'b1, {(DW-1){1'b0}}};

	logic en;

	// head: quadrant fold and guard bits
	logic signed [XW-1:0] ar_x, ai_x, px, py;
	logic signed [ZW-1:0] pz;

	assign ar_x = XW'(cmd.a_re);
	assign ai_x = XW'(cmd.a_im);

	always_comb begin
		px = ar_x;
		py = ai_x;
		pz = '0;
		if (cmd.a_re[DW-1]) begin
			if (!cmd.a_im[DW-1]) begin
				px = ai_x;
				py = -ar_x;
				pz = HP;
			end else begin
				px = -ai_x;
				py = ar_x;
				pz = -HP;
			end
		end
	end

	logic                 valid_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic        [SW-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= px <<< cxalu_pkg::GUARD;
			y_s1    <= py <<< cxalu_pkg::GUARD;
			z_s1    <= pz;
			side_s1 <= {cmd.func, cmd.a_re, cmd.a_im, cmd.b_re, cmd.b_im, cmd.scale};
		end
	end

	// CORDIC chain
	logic                 c_valid [1:N];
	logic signed [XW-1:0] c_x     [1:N];
	logic signed [XW-1:0] c_y     [1:N];
	logic signed [ZW-1:0] c_z     [1:N];
	logic        [SW-1:0] c_side  [1:N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                 pv;
		logic signed [XW-1:0] pxv, pyv;
		logic signed [ZW-1:0] pzv;
		logic        [SW-1:0] psv;

		if (i == 0) begin : g_head
			assign pv  = valid_s1;
			assign pxv = x_s1;
			assign pyv = y_s1;
			assign pzv = z_s1;
			assign psv = side_s1;
		end else begin : g_link
			assign pv  = c_valid[i];
			assign pxv = c_x[i];
			assign pyv = c_y[i];
			assign pzv = c_z[i];
			assign psv = c_side[i];
		end

		cxalu_cell #(
			.STAGE(i),
			.XW(XW),
			.SW(SW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev_valid(pv),
			.prev_x(pxv),
			.prev_y(pyv),
			.prev_z(pzv),
			.prev_side(psv),
			.next_valid(c_valid[i+1]),
			.next_x(c_x[i+1]),
			.next_y(c_y[i+1]),
			.next_z(c_z[i+1]),
			.next_side(c_side[i+1])
		);
	end

	// finishing
	logic                 t_valid, t_eq, t_ov;
	logic signed [DW-1:0] t_re, t_im, t_ph;
	logic        [DW-1:0] t_mag;

	cxalu_tail #(
		.DW(DW),
		.FW(FRAC_BITS),
		.XW(XW)
	) u_tail (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(c_valid[N]),
		.func(c_side[N][5*DW +: FN]),
		.a_re(c_side[N][4*DW +: DW]),
		.a_im(c_side[N][3*DW +: DW]),
		.b_re(c_side[N][2*DW +: DW]),
		.b_im(c_side[N][DW +: DW]),
		.scale(c_side[N][0 +: DW]),
		.x(c_x[N]),
		.z(c_z[N]),
		.res_valid(t_valid),
		.res_re(t_re),
		.res_im(t_im),
		.is_equal(t_eq),
		.magnitude(t_mag),
		.phase(t_ph),
		.overflow(t_ov)
	);

	// output buffer
	logic          room, o_valid;
	logic [OW-1:0] o_word;

	cxalu_skid #(
		.W(OW)
	) u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.push(t_valid && en),
		.data({t_re, t_im, t_eq, t_mag, t_ph, t_ov}),
		.ready(rsp.ready),
		.room(room),
		.valid(o_valid),
		.word(o_word)
	);

	assign en        = room;
	assign cmd.ready = room;

	assign rsp.valid     = o_valid;
	assign rsp.res_re    = o_word[3*DW+2 +: DW];
	assign rsp.res_im    = o_word[2*DW+2 +: DW];
	assign rsp.is_equal  = o_word[2*DW+1];
	assign rsp.magnitude = o_word[DW+1 +: DW];
	assign rsp.phase     = o_word[1 +: DW];
	assign rsp.overflow  = o_word[0];

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.overflow) |->
		(rsp.res_re == RES_MAX || rsp.res_re == RES_MIN ||
		 rsp.res_im == RES_MAX || rsp.res_im == RES_MIN))
		else $error("overflow set without a saturated component");

	a_eq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.is_equal) |->
		(rsp.magnitude == '0 && rsp.phase == '0 && !rsp.overflow &&
		 rsp.res_re == '0 && rsp.res_im == '0))
		else $error("equality word carries other fields");

	a_spare_main: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> rsp.valid)
		else $error("spare slot full while output empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cmd.ready) |-> $past(rsp.valid && !rsp.ready))
		else $error("pipeline stalled without a blocked output word");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for complex_alu_with_polar_top: directed table, then random command words.
// Results are checked against the table's values or a fixed-point predictor with a CORDIC polar conversion.
// Depends on cxalu_pkg, cxalu_ifs and the RTL of complex_alu_with_polar_top.
module testbench;

	localparam int DW             = cxalu_pkg::DATA_WIDTH_DEF;
	localparam int FRAC           = cxalu_pkg::FRAC_BITS_DEF;
	localparam int STAGES         = cxalu_pkg::CORDIC_STAGES_DEF;
	localparam int ANGB           = cxalu_pkg::ANG_BITS;
	localparam int LATENCY        = STAGES + 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_WORDS   = 700;
	localparam int CALM_TAIL      = 100;

	localparam longint SAT_MAX    = (longint'(1) << (DW - 1)) - 1;
	localparam longint SAT_MIN    = -(longint'(1) << (DW - 1));
	localparam longint ROUND_Q    = longint'(1) << (FRAC - 1);
	localparam int     MAG_SHIFT  = ANGB + cxalu_pkg::GUARD;
	localparam longint MAG_ROUND  = longint'(1) << (MAG_SHIFT - 1);
	localparam int     PH_SHIFT   = ANGB - (DW - 3);
	localparam longint PH_ROUND   = longint'(1) << (PH_SHIFT - 1);
	localparam longint MAG_MAX    = (longint'(1) << DW) - 1;

	localparam cxalu_pkg::func_t FN_ADD   = cxalu_pkg::FN_ADD;
	localparam cxalu_pkg::func_t FN_SUB   = cxalu_pkg::FN_SUB;
	localparam cxalu_pkg::func_t FN_MUL   = cxalu_pkg::FN_MUL;
	localparam cxalu_pkg::func_t FN_SCALE = cxalu_pkg::FN_SCALE;
	localparam cxalu_pkg::func_t FN_EQ    = cxalu_pkg::FN_EQ;
	localparam cxalu_pkg::func_t FN_POLAR = cxalu_pkg::FN_POLAR;
	localparam cxalu_pkg::func_t FN_RSVD6 = 3'd6;
	localparam cxalu_pkg::func_t FN_RSVD7 = 3'd7;

	typedef struct packed {
		cxalu_pkg::func_t     func;
		logic signed [DW-1:0] a_re;
		logic signed [DW-1:0] a_im;
		logic signed [DW-1:0] b_re;
		logic signed [DW-1:0] b_im;
		logic signed [DW-1:0] scale;
	} cmd_word_t;

	typedef struct packed {
		logic signed [DW-1:0] res_re;
		logic signed [DW-1:0] res_im;
		logic                 is_equal;
		logic        [DW-1:0] magnitude;
		logic signed [DW-1:0] phase;
		logic                 overflow;
	} outcome_t;

	typedef struct packed {
		cmd_word_t word;
		bit        typed;
		outcome_t  outcome;
	} stim_t;

	typedef struct packed {
		cxalu_pkg::func_t func;
		int    ar, ai, br, bi, sc;
		bit    typed;
		int    rr, ri, eq, mag, ph, ov;
	} row_t;

	logic clk;
	logic arst_n;

	cxalu_in_if  #(.DATA_WIDTH(DW)) cmd ();
	cxalu_out_if #(.DATA_WIDTH(DW)) rsp ();

	complex_alu_with_polar_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// func, a_re, a_im, b_re, b_im, scale, typed, res_re, res_im, eq, mag, phase, ovf
	row_t directed_rows [0:24] = '{
		'{FN_ADD,   32767, -32768,  32767, -32768,      0, 1'b1,  32767, -32768, 0, 0, 0, 1},
		'{FN_ADD,       0,      0,      0,      0,      0, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_SUB,   32767, -32768, -32768,  32767,      0, 1'b1,  32767, -32768, 0, 0, 0, 1},
		'{FN_MUL,    4096,      0,   4096,      0,      0, 1'b1,   4096,      0, 0, 0, 0, 0},
		'{FN_MUL,  -32768, -32768, -32768, -32768,      0, 1'b1,      0,  32767, 0, 0, 0, 1},
		'{FN_MUL,       1,      0,   2048,      0,      0, 1'b1,      1,      0, 0, 0, 0, 0},
		'{FN_MUL,      -1,      0,   2048,      0,      0, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_MUL,   32767, -32768,  32767,  32767,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_SCALE,  4096,  -4096,      0,      0,   8192, 1'b1,   8192,  -8192, 0, 0, 0, 0},
		'{FN_SCALE,-32768,  32767,      0,      0, -32768, 1'b1,  32767, -32768, 0, 0, 0, 1},
		'{FN_SCALE,  5000,  -7000,      0,      0,     -1, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_EQ,      123,     -5,    123,     -5,      0, 1'b1,      0,      0, 1, 0, 0, 0},
		'{FN_EQ,      123,     -5,    124,     -5,      0, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_EQ,      123,     -5,    123,      5,      0, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_EQ,   -32768,  32767, -32768,  32767,      0, 1'b1,      0,      0, 1, 0, 0, 0},
		'{FN_POLAR,     0,      0,      1,      1,      0, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR,  4096,      0,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR,     0,   4096,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR, -4096,      0,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR, -4096,     -1,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR,-32768, -32768,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR, 32767,  32767,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_POLAR,     0, -32768,      0,      0,      0, 1'b0,      0,      0, 0, 0, 0, 0},
		'{FN_RSVD6,  1234,  -4321,  32767, -32768,   4096, 1'b1,      0,      0, 0, 0, 0, 0},
		'{FN_RSVD7,    -1,     -1,     -1,     -1,     -1, 1'b1,      0,      0, 0, 0, 0, 0}
	};

	stim_t    plan_q[$];
	outcome_t pending_outcomes[$];
	int       op_count [0:7];
	int       mismatches;
	int       results_seen;
	int       idle_pct;
	int       stall_left;
	int       quiet_cycles;

	// atan(2^-i) with 30 fraction bits
	function automatic longint micro_angle(int i);
		case (i)
			0: return 843314857;
			1: return 497837829;
			2: return 263043837;
			3: return 133525159;
			4: return 67021687;
			5: return 33543516;
			6: return 16775851;
			7: return 8388437;
			8: return 4194283;
			9: return 2097149;
			default: return (i <= ANGB) ? (longint'(1) << (ANGB - i)) : 0;
		endcase
	endfunction

	function automatic logic signed [DW-1:0] saturate(longint v, inout bit ovf);
		if (v > SAT_MAX) begin
			ovf = 1'b1;
			return SAT_MAX[DW-1:0];
		end
		if (v < SAT_MIN) begin
			ovf = 1'b1;
			return SAT_MIN[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic outcome_t alu_outcome(cmd_word_t w);
		outcome_t o;
		longint ar, ai, br, bi, sc, x, y, z, t, dx, dy, mag, ph;
		bit ovf;
		o = '0;
		ovf = 1'b0;
		ar = w.a_re;
		ai = w.a_im;
		br = w.b_re;
		bi = w.b_im;
		sc = w.scale;
		case (w.func)
			FN_ADD: begin
				o.res_re = saturate(ar + br, ovf);
				o.res_im = saturate(ai + bi, ovf);
			end
			FN_SUB: begin
				o.res_re = saturate(ar - br, ovf);
				o.res_im = saturate(ai - bi, ovf);
			end
			FN_MUL: begin
				o.res_re = saturate((ar * br - ai * bi + ROUND_Q) >>> FRAC, ovf);
				o.res_im = saturate((ar * bi + br * ai + ROUND_Q) >>> FRAC, ovf);
			end
			FN_SCALE: begin
				o.res_re = saturate((ar * sc + ROUND_Q) >>> FRAC, ovf);
				o.res_im = saturate((ai * sc + ROUND_Q) >>> FRAC, ovf);
			end
			FN_EQ: o.is_equal = (ar == br) && (ai == bi);
			FN_POLAR: begin
				if (ar != 0 || ai != 0) begin
					x = ar;
					y = ai;
					z = 0;
					// fold the left half plane by a quarter turn
					if (x < 0) begin
						t = x;
						if (y >= 0) begin
							x = y;
							y = -t;
							z = longint'(cxalu_pkg::HALF_PI);
						end else begin
							x = -y;
							y = t;
							z = -longint'(cxalu_pkg::HALF_PI);
						end
					end
					x = x * (longint'(1) << cxalu_pkg::GUARD);
					y = y * (longint'(1) << cxalu_pkg::GUARD);
					for (int i = 0; i < STAGES; i++) begin
						dx = y >>> i;
						dy = x >>> i;
						if (y >= 0) begin
							x = x + dx;
							y = y - dy;
							z = z + micro_angle(i);
						end else begin
							x = x - dx;
							y = y + dy;
							z = z - micro_angle(i);
						end
					end
					mag = (x * longint'(cxalu_pkg::INV_GAIN) + MAG_ROUND) >>> MAG_SHIFT;
					if (mag > MAG_MAX)
						mag = MAG_MAX;
					if (mag < 0)
						mag = 0;
					ph = (z + PH_ROUND) >>> PH_SHIFT;
					o.magnitude = mag[DW-1:0];
					o.phase = ph[DW-1:0];
				end
			end
			default: ;
		endcase
		o.overflow = ovf;
		return o;
	endfunction

	function automatic logic signed [DW-1:0] random_part();
		case ($urandom_range(0, 9))
			0: return SAT_MIN[DW-1:0];
			1: return SAT_MAX[DW-1:0];
			2: return '0;
			3, 4, 5: return DW'(int'($urandom_range(0, 8191)) - 4096);
			default: return DW'($urandom);
		endcase
	endfunction

	function automatic cmd_word_t random_command();
		cmd_word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		w.a_re = random_part();
		w.a_im = random_part();
		w.b_re = random_part();
		w.b_im = random_part();
		w.scale = random_part();
		if (pick < 17)
			w.func = FN_ADD;
		else if (pick < 34)
			w.func = FN_SUB;
		else if (pick < 52)
			w.func = FN_MUL;
		else if (pick < 68)
			w.func = FN_SCALE;
		else if (pick < 80)
			w.func = FN_EQ;
		else if (pick < 95)
			w.func = FN_POLAR;
		else
			w.func = $urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7;
		if (w.func == FN_EQ) begin
			case ($urandom_range(0, 3))
				0: begin
					w.b_re = w.a_re;
					w.b_im = w.a_im;
				end
				1: w.b_re = w.a_re;
				2: w.b_im = w.a_im;
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: stall bursts and checking
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			outcome_t got, want;
			got = '{rsp.res_re, rsp.res_im, rsp.is_equal, rsp.magnitude, rsp.phase,
				rsp.overflow};
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				$display("%0t: result word %0d with nothing expected: re=%0d im=%0d eq=%0b",
					$time, results_seen, got.res_re, got.res_im, got.is_equal);
			end else begin
				want = pending_outcomes.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: result word %0d mismatch", $time, results_seen);
					$display("  expected re=%0d im=%0d eq=%0b mag=%0d ph=%0d ovf=%0b",
						want.res_re, want.res_im, want.is_equal, want.magnitude,
						want.phase, want.overflow);
					$display("  actual   re=%0d im=%0d eq=%0b mag=%0d ph=%0d ovf=%0b",
						got.res_re, got.res_im, got.is_equal, got.magnitude,
						got.phase, got.overflow);
				end
			end
		end
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 5);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending_outcomes.size());
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stim_t s;
		row_t  r;
		int    idx;
		int    gap_left;
		arst_n = 1'b0;
		cmd.valid <= 1'b0;
		cmd.func <= FN_ADD;
		cmd.a_re <= '0;
		cmd.a_im <= '0;
		cmd.b_re <= '0;
		cmd.b_im <= '0;
		cmd.scale <= '0;
		mismatches = 0;
		results_seen = 0;
		stall_left = 0;
		idle_pct = 30;
		foreach (op_count[i])
			op_count[i] = 0;

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			s.word = '{r.func, r.ar[DW-1:0], r.ai[DW-1:0], r.br[DW-1:0], r.bi[DW-1:0],
				r.sc[DW-1:0]};
			s.typed = r.typed;
			s.outcome = '{r.rr[DW-1:0], r.ri[DW-1:0], r.eq[0], r.mag[DW-1:0],
				r.ph[DW-1:0], r.ov[0]};
			plan_q.push_back(s);
		end
		repeat (RANDOM_WORDS) begin
			s.word = random_command();
			s.typed = 1'b0;
			s.outcome = '0;
			plan_q.push_back(s);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		gap_left = 0;
		while (idx < plan_q.size()) begin
			@(posedge clk);
			if (cmd.valid && cmd.ready) begin
				s = plan_q[idx];
				pending_outcomes.push_back(s.typed ? s.outcome : alu_outcome(s.word));
				op_count[s.word.func]++;
				idx++;
				if (idx % 64 == 0)
					idle_pct = pick_idle_pct();
				if (plan_q.size() - idx < CALM_TAIL)
					idle_pct = 0;
			end
			if (!cmd.valid || cmd.ready) begin
				if (idx >= plan_q.size()) begin
					cmd.valid <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					cmd.valid <= 1'b0;
				end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(0, 5);
					cmd.valid <= 1'b0;
				end else begin
					s = plan_q[idx];
					cmd.valid <= 1'b1;
					cmd.func <= s.word.func;
					cmd.a_re <= s.word.a_re;
					cmd.a_im <= s.word.a_im;
					cmd.b_re <= s.word.b_re;
					cmd.b_im <= s.word.b_im;
					cmd.scale <= s.word.scale;
				end
			end
		end

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("Sent %0d command words: add %0d, sub %0d, mul %0d, scale %0d, eq %0d,",
			idx, op_count[FN_ADD], op_count[FN_SUB], op_count[FN_MUL],
			op_count[FN_SCALE], op_count[FN_EQ]);
		$display("polar %0d, reserved %0d; %0d result words checked, %0d mismatches",
			op_count[FN_POLAR], op_count[FN_RSVD6] + op_count[FN_RSVD7], results_seen,
			mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cxalu_pkg.sv
rtl/cxalu_ifs.sv
rtl/cxalu_cell.sv
rtl/cxalu_tail.sv
rtl/cxalu_skid.sv
rtl/complex_alu_with_polar_top.sv
bench/testbench.sv
